// File: rtl/smr_pkg.sv
// ----------------------------------------------------------------------------
// smr_pkg
// Shared types and constants for the spherical mask with a raised-cosine
// edge: register indexes, controller commands and the cosine table builder.
// ----------------------------------------------------------------------------
package smr_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_ROW_LENGTH  = 3'd0;
    localparam logic [2:0] REG_ROW_COUNT   = 3'd1;
    localparam logic [2:0] REG_CENTER_X    = 3'd2;
    localparam logic [2:0] REG_CENTER_Y    = 3'd3;
    localparam logic [2:0] REG_CENTER_Z    = 3'd4;
    localparam logic [2:0] REG_RADIUS      = 3'd5;
    localparam logic [2:0] REG_TAPER       = 3'd6;
    localparam logic [2:0] REG_INVERT      = 3'd7;

    // Weight of one in Q1.15.
    localparam logic [15:0] MASK_ONE = 16'd32768;

    // Distances in the band stay below 2^32 (Q.8), so the root has 20 bits.
    localparam int ROOT_STEPS = 20;
    localparam int ROOT_W     = 20;
    localparam int RAD_W      = 40;
    localparam int REM_W      = 23;

    // Cosine table construction, Q30.
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned TAYLOR_DIV [0:6] = '{
        64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2
    };

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_Z,
        OP_SQ_R,
        OP_SQ_RT,
        OP_CLASSIFY,
        OP_ROOT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_LOOKUP,
        OP_SCALE,
        OP_EMIT
    } op_t;

    // Status returned to the controller.
    typedef struct packed {
        logic in_band;
        logic out_free;
    } status_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [10:0] row_length;
        logic [10:0] row_count;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] center_z;
        logic [14:0] sphere_radius;
        logic [14:0] taper_width;
        logic        invert_mask;
    } cfg_t;

    // Raised-cosine entry for angle x (Q30), mirrored when neg is set.
    function automatic logic [15:0] cos_entry(longint unsigned x, bit neg);
        longint unsigned x2;
        longint unsigned hm;
        longint unsigned tv;
        longint          c;
        longint          v;
        x2 = (x * x) >> 30;
        c  = longint'(Q30_ONE);
        for (int k = 0; k < 7; k++) begin
            hm = (c < 0) ? 64'd0 : longint'(c);
            tv = ((x2 * hm) >> 30) / TAYLOR_DIV[k];
            c  = longint'(Q30_ONE) - longint'(tv);
        end
        v = neg ? (longint'(Q30_ONE) - c) : (longint'(Q30_ONE) + c);
        if (v < 0) begin
            v = 0;
        end
        v = (v + 32768) >>> 16;
        if (v > 32768) begin
            v = 32768;
        end
        return v[15:0];
    endfunction

endpackage

// File: rtl/smr_ctrl.sv
// ----------------------------------------------------------------------------
// smr_ctrl
// Mask datapath sequencer: steps one voxel through squares, classification,
// root and divide loops and lookup (taper band only), scaling and output.
// ----------------------------------------------------------------------------
module smr_ctrl
    import smr_pkg::*;
#(
    parameter int DIV_STEPS = 9
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output op_t     op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_SQ_R,
        S_SQ_RT,
        S_CLASSIFY,
        S_ROOT,
        S_DIV_INIT,
        S_DIV,
        S_LOOKUP,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t     state_reg;
    logic [4:0] step_reg;

    // State register and loop step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_SQ_X;
                    end
                end
                S_SQ_X:     state_reg <= S_SQ_Y;
                S_SQ_Y:     state_reg <= S_SQ_Z;
                S_SQ_Z:     state_reg <= S_SQ_R;
                S_SQ_R:     state_reg <= S_SQ_RT;
                S_SQ_RT:    state_reg <= S_CLASSIFY;
                S_CLASSIFY:
                begin
                    step_reg  <= '0;
                    state_reg <= status.in_band ? S_ROOT : S_SCALE;
                end
                S_ROOT:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(ROOT_STEPS - 1))
                    begin
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_LOOKUP;
                    end
                end
                S_LOOKUP:   state_reg <= S_SCALE;
                S_SCALE:    state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Command decode.
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:     op = in_valid ? OP_LOAD : OP_IDLE;
            S_SQ_X:     op = OP_SQ_X;
            S_SQ_Y:     op = OP_SQ_Y;
            S_SQ_Z:     op = OP_SQ_Z;
            S_SQ_R:     op = OP_SQ_R;
            S_SQ_RT:    op = OP_SQ_RT;
            S_CLASSIFY: op = OP_CLASSIFY;
            S_ROOT:     op = OP_ROOT_STEP;
            S_DIV_INIT: op = OP_DIV_INIT;
            S_DIV:      op = OP_DIV_STEP;
            S_LOOKUP:   op = OP_LOOKUP;
            S_SCALE:    op = OP_SCALE;
            S_EMIT:     op = OP_EMIT;
            default:    op = OP_IDLE;
        endcase
    end

endmodule

// File: rtl/smr_datapath.sv
// ----------------------------------------------------------------------------
// smr_datapath
// Position counters, shared squaring multiplier, bit-serial square root,
// restoring divider, cosine table and the output register.
// ----------------------------------------------------------------------------
module smr_datapath
    import smr_pkg::*;
#(
    parameter int MAX_SIDE           = 1024,
    parameter int SAMPLE_WIDTH       = 16,
    parameter int COSINE_TABLE_DEPTH = 256,
    parameter int QW                 = 9
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  op_t                            op,
    output status_t                        status,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
    input  logic                           last_in_volume,
    output logic [15:0]                    mask_weight,
    output logic signed [SAMPLE_WIDTH-1:0] masked_sample,
    output logic                           last_out,
    output logic                           out_valid,
    input  logic                           out_ready
);

    localparam int CW  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int EW  = ((CW + 1) > 11) ? (CW + 1) : 11;
    localparam int MW  = (((CW + 4) > 16) ? (CW + 4) : 16) + 2;
    localparam int SW  = 2 * MW + 2;
    localparam int NW  = ROOT_W + QW + 1;
    localparam int PW  = SAMPLE_WIDTH + 17;

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, row_reg, slice_reg;
    logic [CW-1:0] x_reg, y_reg, z_reg;
    logic [EW-1:0] len_ext, cnt_ext;
    logic [EW-1:0] col_inc, row_inc;
    logic [CW:0]   slice_inc;

    always_comb
    begin
        if (cfg.row_length == '0)
            len_ext = EW'(1);
        else if (EW'(cfg.row_length) > EW'(MAX_SIDE))
            len_ext = EW'(MAX_SIDE);
        else
            len_ext = EW'(cfg.row_length);
        if (cfg.row_count == '0)
            cnt_ext = EW'(1);
        else if (EW'(cfg.row_count) > EW'(MAX_SIDE))
            cnt_ext = EW'(MAX_SIDE);
        else
            cnt_ext = EW'(cfg.row_count);
    end

    assign col_inc   = EW'(col_reg) + EW'(1);
    assign row_inc   = EW'(row_reg) + EW'(1);
    assign slice_inc = {1'b0, slice_reg} + (CW+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            slice_reg <= '0;
        end
        else if (op == OP_LOAD)
        begin
            if (last_in_volume)
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                slice_reg <= '0;
            end
            else if (col_inc >= len_ext)
            begin
                col_reg <= '0;
                if (row_inc >= cnt_ext)
                begin
                    row_reg <= '0;
                    if (slice_inc >= (CW+1)'(MAX_SIDE))
                        slice_reg <= '0;
                    else
                        slice_reg <= slice_inc[CW-1:0];
                end
                else
                begin
                    row_reg <= row_inc[CW-1:0];
                end
            end
            else
            begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // Captured item.
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           last_reg;

    always_ff @(posedge clk)
    begin
        if (op == OP_LOAD)
        begin
            sample_reg <= sample_value;
            last_reg   <= last_in_volume;
            x_reg      <= col_reg;
            y_reg      <= row_reg;
            z_reg      <= slice_reg;
        end
    end

    // ------------------------------------------------------------------
    // Shared squaring multiplier and distance accumulation
    // ------------------------------------------------------------------
    logic signed [MW-1:0]   dx, dy, dz, mul_a;
    logic signed [2*MW-1:0] prod_reg;
    logic [SW-1:0]          d2_reg, prod_ext;
    logic [2*MW-1:0]        r2_reg;
    logic [15:0]            rt_sum;

    assign dx = $signed({{(MW-CW-4){1'b0}}, x_reg, 4'b0000})
              - $signed({{(MW-16){cfg.center_x[15]}}, cfg.center_x});
    assign dy = $signed({{(MW-CW-4){1'b0}}, y_reg, 4'b0000})
              - $signed({{(MW-16){cfg.center_y[15]}}, cfg.center_y});
    assign dz = $signed({{(MW-CW-4){1'b0}}, z_reg, 4'b0000})
              - $signed({{(MW-16){cfg.center_z[15]}}, cfg.center_z});
    assign rt_sum = {1'b0, cfg.sphere_radius} + {1'b0, cfg.taper_width};

    always_comb
    begin
        unique case (op)
            OP_SQ_X:  mul_a = dx;
            OP_SQ_Y:  mul_a = dy;
            OP_SQ_Z:  mul_a = dz;
            OP_SQ_R:  mul_a = $signed({{(MW-15){1'b0}}, cfg.sphere_radius});
            OP_SQ_RT: mul_a = $signed({{(MW-16){1'b0}}, rt_sum});
            default:  mul_a = '0;
        endcase
    end

    assign prod_ext = {2'b00, prod_reg};

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_a;
        unique case (op)
            OP_SQ_Y:  d2_reg <= prod_ext;
            OP_SQ_Z:  d2_reg <= d2_reg + prod_ext;
            OP_SQ_R:  d2_reg <= d2_reg + prod_ext;
            OP_SQ_RT: r2_reg <= prod_reg;
            default:  ;
        endcase
    end

    // Classification: the product register holds (r + t)^2 at this point.
    logic in_radius, beyond, hard_edge;

    assign hard_edge      = (cfg.taper_width == '0);
    assign in_radius      = (d2_reg <= {2'b00, r2_reg});
    assign beyond         = (d2_reg > prod_ext);
    assign status.in_band = !hard_edge && !in_radius && !beyond;

    // ------------------------------------------------------------------
    // Square root, two radicand bits per step
    // ------------------------------------------------------------------
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg, rem_shift, trial;
    logic [ROOT_W-1:0] root_reg;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = REM_W'({root_reg, 2'b01});

    // ------------------------------------------------------------------
    // Divider: quotient of the band offset by the taper, one bit per step
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] band_num;
    logic [18:0]       r16;
    logic [NW-1:0]     numer_reg, den_reg;
    logic [QW-1:0]     quo_reg, quo_idx;

    assign r16      = {cfg.sphere_radius, 4'b0000};
    assign band_num = (root_reg > ROOT_W'(r16)) ? (root_reg - ROOT_W'(r16)) : '0;
    assign quo_idx  = (quo_reg > QW'(COSINE_TABLE_DEPTH)) ?
                      QW'(COSINE_TABLE_DEPTH) : quo_reg;

    // Cosine table, built at elaboration.
    logic [15:0] cos_rom [0:COSINE_TABLE_DEPTH];

    for (genvar g = 0; g <= COSINE_TABLE_DEPTH; g++)
    begin : g_cos
        localparam int J = (2 * g > COSINE_TABLE_DEPTH) ? (COSINE_TABLE_DEPTH - g) : g;
        localparam longint unsigned XQ =
            (PI_Q30 * longint'(J)) / longint'(COSINE_TABLE_DEPTH);
        assign cos_rom[g] = cos_entry(XQ, (2 * g > COSINE_TABLE_DEPTH));
    end

    // ------------------------------------------------------------------
    // Weight, scaling and output register
    // ------------------------------------------------------------------
    logic [15:0]          mask_reg, mfin_reg, m_eff;
    logic signed [PW-1:0] sprod_reg;
    logic signed [PW:0]   rnd;
    logic signed [PW:0]   shifted;
    logic signed [SAMPLE_WIDTH-1:0] sat;

    assign m_eff = cfg.invert_mask ? (MASK_ONE - mask_reg) : mask_reg;

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_CLASSIFY:
            begin
                mask_reg <= in_radius ? MASK_ONE : 16'd0;
                rad_reg  <= {d2_reg[31:0], 8'h00};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_ROOT_STEP:
            begin
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            OP_DIV_INIT:
            begin
                numer_reg <= NW'(band_num) * NW'(COSINE_TABLE_DEPTH)
                           + NW'({cfg.taper_width, 3'b000});
                den_reg   <= NW'({cfg.taper_width, 4'b0000}) << (QW - 1);
                quo_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                den_reg <= den_reg >> 1;
                if (numer_reg >= den_reg)
                begin
                    numer_reg <= numer_reg - den_reg;
                    quo_reg   <= {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
            end
            OP_LOOKUP:
            begin
                mask_reg <= cos_rom[quo_idx];
            end
            OP_SCALE:
            begin
                mfin_reg  <= m_eff;
                sprod_reg <= sample_reg * $signed({1'b0, m_eff});
            end
            default: ;
        endcase
    end

    // Round to nearest and saturate to the sample range.
    assign rnd     = (PW+1)'(sprod_reg) + (PW+1)'(16384);
    assign shifted = rnd >>> 15;

    always_comb
    begin
        priority if (shifted > (PW+1)'($signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}})))
            sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        else if (shifted < $signed({{(PW-SAMPLE_WIDTH+2){1'b1}},
                                    {(SAMPLE_WIDTH-1){1'b0}}}))
            sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            sat = shifted[SAMPLE_WIDTH-1:0];
    end

    assign status.out_free = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (op == OP_EMIT && status.out_free)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_EMIT && status.out_free)
        begin
            mask_weight   <= mfin_reg;
            masked_sample <= sat;
            last_out      <= last_reg;
        end
    end

endmodule

// File: rtl/spherical_mask_raised_cosine_top.sv
// ----------------------------------------------------------------------------
// spherical_mask_raised_cosine_top
// Applies a spherical mask with an optional raised-cosine edge to a stream
// of voxels in raster order.
// ----------------------------------------------------------------------------
// Usage:
// Voxels enter on the in_valid/in_ready channel, x fastest; last_in_volume
// on the final voxel returns the position counters to the origin. Each
// transaction yields one result on out_valid/out_ready carrying the weight,
// the weighted sample and the last flag.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce this. cfg_ready is always high.
// A voxel inside the hard mask or outside the taper band skips the root,
// divide and lookup steps; a voxel in the taper band also runs the 20-step
// square root and one-bit-per-cycle divider. One item is in work at a time.
// The result sits in an output register: a stalled receiver only holds the
// block in its last step while the result waits there.
// Reset clears the counters, config registers and out_valid; no clearing pass.
// ----------------------------------------------------------------------------
module spherical_mask_raised_cosine_top
    import smr_pkg::*;
#(
    parameter int MAX_SIDE           = 1024,
    parameter int SAMPLE_WIDTH       = 16,
    parameter int COSINE_TABLE_DEPTH = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
    input  logic                           last_in_volume,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [15:0]                    mask_weight,
    output logic signed [SAMPLE_WIDTH-1:0] masked_sample,
    output logic                           last_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);

    localparam int QW = $clog2(COSINE_TABLE_DEPTH + 1);

    cfg_t    cfg_reg;
    op_t     op;
    status_t status;

    assign cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{row_length: 11'd1, row_count: 11'd1,
                         center_x: 16'd0, center_y: 16'd0, center_z: 16'd0,
                         sphere_radius: 15'd0, taper_width: 15'd0,
                         invert_mask: 1'b0};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW_LENGTH: cfg_reg.row_length    <= cfg_data[10:0];
                REG_ROW_COUNT:  cfg_reg.row_count     <= cfg_data[10:0];
                REG_CENTER_X:   cfg_reg.center_x      <= cfg_data;
                REG_CENTER_Y:   cfg_reg.center_y      <= cfg_data;
                REG_CENTER_Z:   cfg_reg.center_z      <= cfg_data;
                REG_RADIUS:     cfg_reg.sphere_radius <= cfg_data[14:0];
                REG_TAPER:      cfg_reg.taper_width   <= cfg_data[14:0];
                REG_INVERT:     cfg_reg.invert_mask   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    smr_ctrl #(
        .DIV_STEPS (QW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    smr_datapath #(
        .MAX_SIDE           (MAX_SIDE),
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH),
        .QW                 (QW)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .op             (op),
        .status         (status),
        .sample_value   (sample_value),
        .last_in_volume (last_in_volume),
        .mask_weight    (mask_weight),
        .masked_sample  (masked_sample),
        .last_out       (last_out),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

endmodule
